// ----- design/strided_range_set_table_unit_macros.svh -----
// Assertion macros for the strided section set table.
// Included by the top level; define NO_ASSERTIONS to drop the checks.
`ifndef STRIDED_RANGE_SET_TABLE_UNIT_MACROS_SVH
`define STRIDED_RANGE_SET_TABLE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SRST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SRST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SRST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/srst_pkg.sv -----
// Shared types and constants for the strided section set table.
// No dependencies.
package srst_pkg;
	localparam int unsigned SrstMaxSections = 16;
	localparam int unsigned SrstValueBits = 24;

	localparam logic [2:0] KIND_CLEAR    = 3'd0;
	localparam logic [2:0] KIND_APPEND   = 3'd1;
	localparam logic [2:0] KIND_CONTAINS = 3'd2;
	localparam logic [2:0] KIND_NEXT     = 3'd3;
	localparam logic [2:0] KIND_ADD      = 3'd4;
	localparam logic [2:0] KIND_REMOVE   = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FALSE   = 3'd1;
	localparam logic [2:0] ST_NO_NEXT = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
endpackage

// ----- design/strided_range_set_table_unit.sv -----
// Top level of the strided section set table: sequencer around the section store.
// Uses srst_pkg, srst_mem, srst_divider and the assertion macro header.
//
// channel   dir  handshake            payload
// request   in   valid / ready        kind value section_last section_stride
//                                     want_first allow_restep
// result    out  out_valid/out_ready  status result_value sections_in_use
//
// One request at a time. Each section visited costs a memory read plus a divide in the
// serial divider, so a lookup walks the used sections in turn. Add and remove walk the
// sections a second time when an edit is needed, append does one divide and one write,
// and removal compaction moves each following section down by one entry.
// Reset empties the table at once. A waiting result holds the sequencer in its done
// state, which keeps ready low.
`include "strided_range_set_table_unit_macros.svh"
module strided_range_set_table_unit import srst_pkg::*; #(
	parameter int unsigned MAX_SECTIONS = SrstMaxSections,
	parameter int unsigned VALUE_BITS = SrstValueBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  ready,
	input  logic [2:0]            kind,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [VALUE_BITS-1:0] section_last,
	input  logic [VALUE_BITS-1:0] section_stride,
	input  logic                  want_first,
	input  logic                  allow_restep,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [VALUE_BITS-1:0] result_value,
	output logic [$clog2(MAX_SECTIONS+1)-1:0] sections_in_use
);
	localparam int unsigned W = VALUE_BITS;
	localparam int unsigned AW = $clog2(MAX_SECTIONS);
	localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);
	localparam int unsigned DW = 4 * W + 1;

	typedef struct packed {
		logic [W-1:0] first;
		logic [W-1:0] last;
		logic [W-1:0] stride;
		logic [W:0]   members;
	} sec_t;

	typedef enum logic [3:0] {
		S_IDLE, S_APPDIV, S_MEMRD, S_MEMWAIT, S_DIVWAIT, S_DECIDE,
		S_ADDRD, S_ADDWAIT, S_TAILWAIT, S_MOVERD, S_MOVEWAIT, S_DONE
	} state_t;

	state_t state_q;
	logic [2:0] kind_q;
	logic [W-1:0] val_q, lastv_q, strd_q;
	logic first_q, restep_q;
	logic [CW-1:0] used_q, idx_q;
	logic found_q, endat_q;
	logic [W-1:0] res_q;
	logic [2:0] st_q;
	logic pend_q;
	logic phase2_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	sec_t wsec, rsec;
	logic [DW-1:0] rdata;
	logic div_start, div_done;
	logic [W-1:0] div_a, div_b, div_q, div_r;

	srst_mem #(.DEPTH(MAX_SECTIONS), .DW(DW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wsec), .raddr(raddr), .rdata(rdata)
	);
	assign rsec = sec_t'(rdata);

	srst_divider #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
		.done(div_done), .quotient(div_q), .remainder(div_r)
	);

	sec_t cur_q;
	logic in_rng, hit;
	logic [W:0] dn_sum, up_sum;
	assign in_rng = (val_q >= cur_q.first) && (val_q <= cur_q.last);
	assign hit = in_rng && (cur_q.stride == '0 ? val_q == cur_q.first : div_r == '0);
	assign dn_sum = {1'b0, val_q} + {1'b0, cur_q.stride};
	assign up_sum = {1'b0, cur_q.last} + {1'b0, cur_q.stride};

	assign ready = (state_q == S_IDLE) && !pend_q;

	// membership divide starts as the section leaves the memory, so take it from rdata
	always_comb begin
		div_a = (state_q == S_IDLE) ? section_last - value : val_q - rsec.first;
		div_b = (state_q == S_IDLE) ? section_stride : rsec.stride;
		div_start = (valid && ready && kind == KIND_APPEND) ||
			(state_q == S_MEMWAIT && !phase2_q);
		raddr = idx_q[AW-1:0];
	end

	// Sequencer. Phase 1 walks sections testing membership (found_q); phase 2 for
	// add/remove walks again looking for the edit target.
	logic [W-1:0] prod;
	assign prod = W'(div_q * strd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			pend_q <= 1'b0;
			out_valid <= 1'b0;
			we <= 1'b0;
		end else begin
			we <= 1'b0;
			if (out_valid && out_ready && state_q != S_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (valid && ready) begin
						kind_q <= kind;
						val_q <= value;
						lastv_q <= section_last;
						strd_q <= section_stride;
						first_q <= want_first;
						restep_q <= allow_restep;
						idx_q <= '0;
						found_q <= 1'b0;
						endat_q <= 1'b0;
						phase2_q <= 1'b0;
						res_q <= '0;
						pend_q <= 1'b1;
						priority case (kind)
							KIND_CLEAR: begin
								used_q <= '0;
								st_q <= ST_OK;
								state_q <= S_DONE;
							end
							KIND_APPEND: begin
								if (value > section_last || section_stride == '0) begin
									st_q <= ST_INVALID;
									state_q <= S_DONE;
								end else if (used_q >= CW'(MAX_SECTIONS)) begin
									st_q <= ST_FULL;
									state_q <= S_DONE;
								end else
									state_q <= S_APPDIV;
							end
							KIND_CONTAINS, KIND_ADD, KIND_REMOVE: state_q <= S_MEMRD;
							KIND_NEXT: begin
								if (used_q == '0) begin
									st_q <= ST_FALSE;
									state_q <= S_DONE;
								end else
									state_q <= S_MEMRD;
							end
							default: begin
								st_q <= ST_INVALID;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_APPDIV: begin
					if (div_done) begin
						we <= 1'b1;
						waddr <= used_q[AW-1:0];
						wsec <= '{first: val_q, last: val_q + prod, stride: strd_q,
							members: {1'b0, div_q} + 1'b1};
						used_q <= used_q + 1'b1;
						st_q <= ST_OK;
						state_q <= S_DONE;
					end
				end
				S_MEMRD: begin
					// end of walk
					if (idx_q >= used_q) begin
						state_q <= S_DECIDE;
					end else
						state_q <= S_MEMWAIT;
				end
				S_MEMWAIT: begin
					cur_q <= rsec;
					state_q <= (kind_q == KIND_NEXT && first_q) ? S_DECIDE :
						(phase2_q ? S_ADDWAIT : S_DIVWAIT);
				end
				S_DIVWAIT: begin
					if (div_done) begin
						if (kind_q == KIND_NEXT && hit && !found_q) begin
							found_q <= 1'b1;
							if (val_q != cur_q.last) begin
								res_q <= dn_sum[W-1:0];
								endat_q <= 1'b0;
								state_q <= S_DECIDE;
							end else if (idx_q + 1'b1 < used_q) begin
								endat_q <= 1'b1;
								idx_q <= idx_q + 1'b1;
								state_q <= S_MEMRD;
							end else begin
								endat_q <= 1'b0;
								idx_q <= idx_q + 1'b1;
								state_q <= S_MEMRD;
							end
						end else if (kind_q == KIND_NEXT && endat_q) begin
							res_q <= cur_q.first;
							state_q <= S_DECIDE;
						end else if (hit && kind_q != KIND_NEXT) begin
							found_q <= 1'b1;
							idx_q <= used_q;
							state_q <= S_DECIDE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_MEMRD;
						end
					end
				end
				S_DECIDE: begin
					if (!phase2_q) begin
						unique case (kind_q)
							KIND_CONTAINS: begin
								st_q <= found_q ? ST_OK : ST_FALSE;
								state_q <= S_DONE;
							end
							KIND_NEXT: begin
								state_q <= S_DONE;
								if (first_q) begin
									res_q <= cur_q.first;
									st_q <= ST_OK;
								end else if (!found_q)
									st_q <= ST_FALSE;
								else if (endat_q) begin
									res_q <= cur_q.first;
									st_q <= ST_OK;
								end else if (res_q == '0 && idx_q >= used_q)
									st_q <= ST_NO_NEXT;
								else
									st_q <= ST_OK;
							end
							KIND_ADD, KIND_REMOVE: begin
								if (found_q == (kind_q == KIND_ADD)) begin
									st_q <= ST_FALSE;
									state_q <= S_DONE;
								end else begin
									phase2_q <= 1'b1;
									idx_q <= '0;
									state_q <= S_ADDRD;
								end
							end
							default: begin
								st_q <= ST_INVALID;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_DONE;
						// phase-2 walk finished without an edge match
						if (kind_q == KIND_REMOVE)
							st_q <= ST_FALSE;
						else if (used_q != '0 && restep_q && cur_q.members == (W+1)'(1)) begin
							we <= 1'b1;
							waddr <= AW'(used_q - 1'b1);
							if (cur_q.first < val_q)
								wsec <= '{first: cur_q.first, last: val_q,
									stride: val_q - cur_q.first, members: (W+1)'(2)};
							else
								wsec <= '{first: val_q, last: cur_q.last,
									stride: cur_q.last - val_q, members: (W+1)'(2)};
							st_q <= ST_OK;
						end else if (used_q >= CW'(MAX_SECTIONS))
							st_q <= ST_FULL;
						else begin
							we <= 1'b1;
							waddr <= used_q[AW-1:0];
							wsec <= '{first: val_q, last: val_q, stride: W'(1),
								members: (W+1)'(1)};
							used_q <= used_q + 1'b1;
							st_q <= ST_OK;
						end
					end
				end
				S_ADDRD: begin
					if (idx_q >= used_q)
						state_q <= S_DECIDE;
					else
						state_q <= S_MEMWAIT;
				end
				S_ADDWAIT: begin
					if (kind_q == KIND_ADD && dn_sum == {1'b0, cur_q.first}) begin
						we <= 1'b1;
						waddr <= idx_q[AW-1:0];
						wsec <= '{first: val_q, last: cur_q.last, stride: cur_q.stride,
							members: cur_q.members + 1'b1};
						st_q <= ST_OK;
						state_q <= S_DONE;
					end else if (kind_q == KIND_ADD && up_sum == {1'b0, val_q}) begin
						we <= 1'b1;
						waddr <= idx_q[AW-1:0];
						wsec <= '{first: cur_q.first, last: val_q, stride: cur_q.stride,
							members: cur_q.members + 1'b1};
						st_q <= ST_OK;
						state_q <= S_DONE;
					end else if (kind_q == KIND_REMOVE &&
						(cur_q.first == val_q || cur_q.last == val_q)) begin
						st_q <= ST_OK;
						if (cur_q.members == (W+1)'(1)) begin
							used_q <= used_q - 1'b1;
							idx_q <= idx_q + 1'b1;
							state_q <= S_MOVERD;
						end else begin
							we <= 1'b1;
							waddr <= idx_q[AW-1:0];
							state_q <= S_DONE;
							if (cur_q.first == val_q)
								wsec <= '{first: W'(cur_q.first + cur_q.stride),
									last: cur_q.last, stride: cur_q.stride,
									members: cur_q.members - 1'b1};
							else
								wsec <= '{first: cur_q.first,
									last: cur_q.last - cur_q.stride, stride: cur_q.stride,
									members: cur_q.members - 1'b1};
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= (idx_q + 1'b1 >= used_q) ? S_DECIDE : S_ADDRD;
					end
				end
				S_MOVERD: begin
					// compaction: idx_q points one past the hole
					if (idx_q > used_q)
						state_q <= S_DONE;
					else
						state_q <= S_MOVEWAIT;
				end
				S_MOVEWAIT: begin
					we <= 1'b1;
					waddr <= AW'(idx_q - 1'b1);
					wsec <= rsec;
					idx_q <= idx_q + 1'b1;
					state_q <= S_MOVERD;
				end
				S_TAILWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status <= st_q;
						result_value <= (st_q == ST_OK && kind_q == KIND_NEXT) ? res_q : '0;
						sections_in_use <= used_q;
						pend_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// the tail entry is needed by add's restep check; read it last
			if (state_q == S_ADDRD && idx_q >= used_q && used_q != '0)
				idx_q <= used_q - 1'b1;
		end
	end

	`SRST_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, used_q <= CW'(MAX_SECTIONS))
	`SRST_ASSERT_IMPL(a_status_range, clk, arst_n, out_valid, status <= ST_FULL)
	`SRST_ASSERT_NEXT(a_accept_busy, clk, arst_n, valid && ready, !ready)
endmodule

// ----- design/srst_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses srst_pkg. Also gives the remainder, used for stride membership tests.
module srst_divider import srst_pkg::*; #(
	parameter int unsigned W = SrstValueBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] quo_q, den_q;
	logic [W:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic         busy_q;
	logic [W:0]   shifted;
	logic [W:0]   diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q[W-1:0];
endmodule

// ----- design/srst_mem.sv -----
// Section store: one synchronous memory, one read and one write port.
// Uses srst_pkg. Entry holds first, last, stride and member count.
module srst_mem import srst_pkg::*; #(
	parameter int unsigned DEPTH = SrstMaxSections,
	parameter int unsigned DW = 4 * SrstValueBits + 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
